// File: rtl/core/upk_pkg.sv
// Package for the pixel art upscale kernel: widths, coefficients, codes and shared types.
// Depends on nothing; every other file of the kernel uses it.
`default_nettype none

package upk_pkg;

   // Pixel and channel widths.
   localparam int PIXEL_W = 32;
   localparam int CHAN_W  = 8;
   localparam int NUM_SUB = 9;

   // Distance arithmetic widths. Weighted sums stay within +/-313650.
   localparam int NUM_W  = 20;
   localparam int ABS_W  = 19;
   localparam int QUO_W  = 9;
   localparam int DIST_W = 11;
   localparam int THR_W  = 11;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_SCALE_MODE = 2'd0;
   localparam csr_index_type CSR_THRESHOLD  = 2'd1;

   localparam logic             MODE_2X         = 1'b0;
   localparam logic             MODE_3X         = 1'b1;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 11'd30;

   // YUV weights, scaled by 1000.
   localparam logic signed [NUM_W-1:0] COEF_Y_R = 20'sd299;
   localparam logic signed [NUM_W-1:0] COEF_Y_G = 20'sd587;
   localparam logic signed [NUM_W-1:0] COEF_Y_B = 20'sd114;
   localparam logic signed [NUM_W-1:0] COEF_U_B = 20'sd436;
   localparam logic signed [NUM_W-1:0] COEF_U_R = 20'sd147;
   localparam logic signed [NUM_W-1:0] COEF_U_G = 20'sd289;
   localparam logic signed [NUM_W-1:0] COEF_V_R = 20'sd615;
   localparam logic signed [NUM_W-1:0] COEF_V_G = 20'sd515;
   localparam logic signed [NUM_W-1:0] COEF_V_B = 20'sd100;

   // Division by 1000 as multiplication by ceil(2^28 / 1000), exact below 493999.
   localparam logic [ABS_W-1:0] RECIP_K     = 19'd268436;
   localparam int               RECIP_SHIFT = 28;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // Similarity flags of the ten compared pairs.
   typedef struct packed {
      logic lr;
      logic ud;
      logic ul;
      logic ur;
      logic dl;
      logic dr;
      logic cul;
      logic cur;
      logic cdl;
      logic cdr;
   } sim_flags_type;

   // Advance enables of the four distance stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   // Per channel (3*e + c) / 4, alpha included.
   function automatic pixel_type blend31(input pixel_type e, input pixel_type c);
      pixel_type              res;
      logic [CHAN_W+1:0]      acc;
      res = '0;
      for (int k = 0; k < PIXEL_W / CHAN_W; k++) begin
         acc = (CHAN_W+2)'(e[k*CHAN_W +: CHAN_W]) * (CHAN_W+2)'(3)
             + (CHAN_W+2)'(c[k*CHAN_W +: CHAN_W]);
         res[k*CHAN_W +: CHAN_W] = acc[CHAN_W+1:2];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/upk_channels_if.sv
// Channel interfaces of the upscale kernel: source window, result block and register writes.
// Depends on upk_pkg for widths.
`default_nettype none

interface upk_req_if;
   logic                   valid;
   logic                   ready;
   logic [upk_pkg::PIXEL_W-1:0] center_pixel;
   logic [upk_pkg::PIXEL_W-1:0] up_pixel;
   logic [upk_pkg::PIXEL_W-1:0] down_pixel;
   logic [upk_pkg::PIXEL_W-1:0] left_pixel;
   logic [upk_pkg::PIXEL_W-1:0] right_pixel;
   logic [upk_pkg::PIXEL_W-1:0] up_left_pixel;
   logic [upk_pkg::PIXEL_W-1:0] up_right_pixel;
   logic [upk_pkg::PIXEL_W-1:0] down_left_pixel;
   logic [upk_pkg::PIXEL_W-1:0] down_right_pixel;

   modport source (output valid, center_pixel, up_pixel, down_pixel, left_pixel,
                   right_pixel, up_left_pixel, up_right_pixel, down_left_pixel,
                   down_right_pixel, input ready);
   modport sink   (input valid, center_pixel, up_pixel, down_pixel, left_pixel,
                   right_pixel, up_left_pixel, up_right_pixel, down_left_pixel,
                   down_right_pixel, output ready);
endinterface

interface upk_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [upk_pkg::PIXEL_W-1:0] sub_0;
   logic [upk_pkg::PIXEL_W-1:0] sub_1;
   logic [upk_pkg::PIXEL_W-1:0] sub_2;
   logic [upk_pkg::PIXEL_W-1:0] sub_3;
   logic [upk_pkg::PIXEL_W-1:0] sub_4;
   logic [upk_pkg::PIXEL_W-1:0] sub_5;
   logic [upk_pkg::PIXEL_W-1:0] sub_6;
   logic [upk_pkg::PIXEL_W-1:0] sub_7;
   logic [upk_pkg::PIXEL_W-1:0] sub_8;

   modport source (output valid, sub_0, sub_1, sub_2, sub_3, sub_4, sub_5, sub_6,
                   sub_7, sub_8, input ready);
   modport sink   (input valid, sub_0, sub_1, sub_2, sub_3, sub_4, sub_5, sub_6,
                   sub_7, sub_8, output ready);
endinterface

interface upk_csr_if;
   logic                            valid;
   logic                            ready;
   logic [upk_pkg::CSR_INDEX_W-1:0] index;
   logic [upk_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/upk_sim.sv
// Four stage color similarity unit: weighted sums, magnitudes, division by 1000, compare.
// Depends on upk_pkg; advance enables come from the top level pipeline control.
`default_nettype none

module upk_sim (
   input  wire                      clock,
   input  upk_pkg::stage_en_type    en,
   input  upk_pkg::pixel_type       pix_a,
   input  upk_pkg::pixel_type       pix_b,
   input  wire [upk_pkg::THR_W-1:0] threshold,
   output logic                     similar
);
   import upk_pkg::*;

   logic signed [NUM_W-1:0] d_r, d_g, d_b;
   logic signed [NUM_W-1:0] ny_in, nu_in, nv_in, ny_ff, nu_ff, nv_ff;
   logic [ABS_W-1:0]        ay_in, au_in, av_in, ay_ff, au_ff, av_ff;
   logic [2*ABS_W-1:0]      prod_y, prod_u, prod_v;
   logic [QUO_W-1:0]        qy_in, qu_in, qv_in, qy_ff, qu_ff, qv_ff;
   logic [DIST_W-1:0]       dist_sum;
   logic                    similar_in, similar_ff;

   // Stage 1: channel differences and the three weighted sums.
   assign d_r = $signed({{(NUM_W-CHAN_W){1'b0}}, pix_a[23:16]})
              - $signed({{(NUM_W-CHAN_W){1'b0}}, pix_b[23:16]});
   assign d_g = $signed({{(NUM_W-CHAN_W){1'b0}}, pix_a[15:8]})
              - $signed({{(NUM_W-CHAN_W){1'b0}}, pix_b[15:8]});
   assign d_b = $signed({{(NUM_W-CHAN_W){1'b0}}, pix_a[7:0]})
              - $signed({{(NUM_W-CHAN_W){1'b0}}, pix_b[7:0]});

   assign ny_in = d_r * COEF_Y_R + d_g * COEF_Y_G + d_b * COEF_Y_B;
   assign nu_in = d_b * COEF_U_B - d_r * COEF_U_R - d_g * COEF_U_G;
   assign nv_in = d_r * COEF_V_R - d_g * COEF_V_G - d_b * COEF_V_B;

   // Stage 2: magnitudes. The truncated quotient magnitude equals floor(|n| / 1000).
   assign ay_in = ny_ff[NUM_W-1] ? ABS_W'(-ny_ff) : ABS_W'(ny_ff);
   assign au_in = nu_ff[NUM_W-1] ? ABS_W'(-nu_ff) : ABS_W'(nu_ff);
   assign av_in = nv_ff[NUM_W-1] ? ABS_W'(-nv_ff) : ABS_W'(nv_ff);

   // Stage 3: division by 1000 through the reciprocal.
   assign prod_y = (2*ABS_W)'(ay_ff) * (2*ABS_W)'(RECIP_K);
   assign prod_u = (2*ABS_W)'(au_ff) * (2*ABS_W)'(RECIP_K);
   assign prod_v = (2*ABS_W)'(av_ff) * (2*ABS_W)'(RECIP_K);
   assign qy_in  = prod_y[RECIP_SHIFT +: QUO_W];
   assign qu_in  = prod_u[RECIP_SHIFT +: QUO_W];
   assign qv_in  = prod_v[RECIP_SHIFT +: QUO_W];

   // Stage 4: distance and threshold compare.
   assign dist_sum   = DIST_W'({qy_ff, 1'b0}) + DIST_W'(qu_ff) + DIST_W'(qv_ff);
   assign similar_in = (dist_sum < threshold);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         ny_ff <= ny_in;
         nu_ff <= nu_in;
         nv_ff <= nv_in;
      end
      if (en.s2) begin
         ay_ff <= ay_in;
         au_ff <= au_in;
         av_ff <= av_in;
      end
      if (en.s3) begin
         qy_ff <= qy_in;
         qu_ff <= qu_in;
         qv_ff <= qv_in;
      end
      if (en.s4) begin
         similar_ff <= similar_in;
      end
   end

   assign similar = similar_ff;

endmodule

`default_nettype wire

// File: rtl/core/upk_select.sv
// Edge rule selection: builds the 2x or 3x subpixel block from the similarity flags.
// Depends on upk_pkg for the flag struct and the blend function.
`default_nettype none

module upk_select (
   input  wire                                 mode_3x,
   input  upk_pkg::sim_flags_type              flags,
   input  upk_pkg::pixel_type                  c_pix,
   input  upk_pkg::pixel_type                  u_pix,
   input  upk_pkg::pixel_type                  d_pix,
   input  upk_pkg::pixel_type                  l_pix,
   input  upk_pkg::pixel_type                  r_pix,
   output upk_pkg::pixel_type [upk_pkg::NUM_SUB-1:0] subs
);
   import upk_pkg::*;

   pixel_type blend_u, blend_d;
   pixel_type tl, tr, bl, br, tm, ml, mr, bm;
   logic      flat;

   // Corner blends and edge copies.
   assign blend_u = blend31(u_pix, c_pix);
   assign blend_d = blend31(d_pix, c_pix);
   assign flat    = flags.lr | flags.ud;

   assign tl = flags.ul ? blend_u : c_pix;
   assign tr = flags.ur ? blend_u : c_pix;
   assign bl = flags.dl ? blend_d : c_pix;
   assign br = flags.dr ? blend_d : c_pix;

   assign tm = ((flags.ul & ~flags.cur) | (flags.ur & ~flags.cul)) ? u_pix : c_pix;
   assign ml = ((flags.ul & ~flags.cdl) | (flags.dl & ~flags.cul)) ? l_pix : c_pix;
   assign mr = ((flags.ur & ~flags.cdr) | (flags.dr & ~flags.cur)) ? r_pix : c_pix;
   assign bm = ((flags.dl & ~flags.cdr) | (flags.dr & ~flags.cdl)) ? d_pix : c_pix;

   // Block placement per mode; a flat block is the center throughout (in 2x mode subs 0 to 3, the rest zero).
   always_comb begin
      subs = '0;
      if (mode_3x == MODE_3X) begin
         for (int k = 0; k < NUM_SUB; k++) begin
            subs[k] = c_pix;
         end
         if (!flat) begin
            subs[0] = tl;
            subs[1] = tm;
            subs[2] = tr;
            subs[3] = ml;
            subs[5] = mr;
            subs[6] = bl;
            subs[7] = bm;
            subs[8] = br;
         end
      end else begin
         if (flat) begin
            subs[0] = c_pix;
            subs[1] = c_pix;
            subs[2] = c_pix;
            subs[3] = c_pix;
         end else begin
            subs[0] = tl;
            subs[1] = tr;
            subs[2] = bl;
            subs[3] = br;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/pixel_art_upscale_kernel_top.sv
// Top level of the pixel art upscale kernel: registers, pipeline control and output stage.
// Depends on upk_pkg, upk_channels_if, upk_sim and upk_select.
//
//   Channel   Dir   Width (bits)            Transfer when
//   req_chan  in    9 x 32 pixels           req_chan.valid && req_chan.ready
//   rsp_chan  out   9 x 32 subpixels        rsp_chan.valid && rsp_chan.ready
//   csr_chan  in    2 index + 11 data       csr_chan.valid && csr_chan.ready
//
// One source pixel is accepted per clock while req_chan.ready is high; each result passes
// through the four distance stages and the output register before it shows on rsp_chan.
// Reset clears all valid bits and returns scale_mode to 2x and the threshold to 30.
// A stall on rsp_chan holds an occupied stage only when all later stages are occupied;
// items behind an empty stage move up, so req_chan.ready drops only when all five
// stages hold an item and rsp_chan.ready is low.
// The register port always accepts; writes to unused indexes are dropped.
`default_nettype none

module pixel_art_upscale_kernel_top (
   input  wire         clock,
   input  wire         reset,
   upk_req_if.sink     req_chan,
   upk_rsp_if.source   rsp_chan,
   upk_csr_if.sink     csr_chan
);
   import upk_pkg::*;

   localparam int DEPTH = 4;

   typedef struct packed {
      pixel_type c;
      pixel_type u;
      pixel_type d;
      pixel_type l;
      pixel_type r;
   } carry_type;

   logic                        mode_ff, mode_in;
   logic [THR_W-1:0]            thr_ff, thr_in;
   logic [DEPTH-1:0]            valid_ff, valid_in;
   logic                        out_valid_ff, out_valid_in;
   logic [DEPTH:0]              adv;
   stage_en_type                en;
   carry_type                   carry_ff [DEPTH];
   carry_type                   carry_new;
   sim_flags_type               flags;
   pixel_type [NUM_SUB-1:0]     subs;
   pixel_type [NUM_SUB-1:0]     sub_ff;

   // Register writes.
   always_comb begin
      mode_in = mode_ff;
      thr_in  = thr_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SCALE_MODE: mode_in = csr_chan.data[0];
            CSR_THRESHOLD:  thr_in  = csr_chan.data[THR_W-1:0];
            default: ;
         endcase
      end
   end
   assign csr_chan.ready = 1'b1;

   // Pipeline control: a stage advances when it is empty or the next one advances.
   always_comb begin
      adv[DEPTH] = ~out_valid_ff | rsp_chan.ready;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         adv[k] = ~valid_ff[k] | adv[k+1];
      end
   end
   assign en = '{s1: adv[0], s2: adv[1], s3: adv[2], s4: adv[3]};
   assign req_chan.ready = adv[0];

   always_comb begin
      valid_in     = valid_ff;
      out_valid_in = out_valid_ff;
      if (adv[0]) begin
         valid_in[0] = req_chan.valid;
      end
      for (int k = 1; k < DEPTH; k++) begin
         if (adv[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
      if (adv[DEPTH]) begin
         out_valid_in = valid_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_2X;
         thr_ff       <= THRESHOLD_RESET;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         thr_ff       <= thr_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Pixels needed by the selection travel alongside the distance stages.
   assign carry_new = '{c: req_chan.center_pixel, u: req_chan.up_pixel,
                        d: req_chan.down_pixel, l: req_chan.left_pixel,
                        r: req_chan.right_pixel};

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         carry_ff[0] <= carry_new;
      end
      for (int k = 1; k < DEPTH; k++) begin
         if (adv[k]) begin
            carry_ff[k] <= carry_ff[k-1];
         end
      end
   end

   // Ten similarity units, one per compared pair.
   upk_sim u_sim_lr (.clock(clock), .en(en), .pix_a(req_chan.left_pixel),
      .pix_b(req_chan.right_pixel), .threshold(thr_ff), .similar(flags.lr));
   upk_sim u_sim_ud (.clock(clock), .en(en), .pix_a(req_chan.up_pixel),
      .pix_b(req_chan.down_pixel), .threshold(thr_ff), .similar(flags.ud));
   upk_sim u_sim_ul (.clock(clock), .en(en), .pix_a(req_chan.up_pixel),
      .pix_b(req_chan.left_pixel), .threshold(thr_ff), .similar(flags.ul));
   upk_sim u_sim_ur (.clock(clock), .en(en), .pix_a(req_chan.up_pixel),
      .pix_b(req_chan.right_pixel), .threshold(thr_ff), .similar(flags.ur));
   upk_sim u_sim_dl (.clock(clock), .en(en), .pix_a(req_chan.down_pixel),
      .pix_b(req_chan.left_pixel), .threshold(thr_ff), .similar(flags.dl));
   upk_sim u_sim_dr (.clock(clock), .en(en), .pix_a(req_chan.down_pixel),
      .pix_b(req_chan.right_pixel), .threshold(thr_ff), .similar(flags.dr));
   upk_sim u_sim_cul (.clock(clock), .en(en), .pix_a(req_chan.center_pixel),
      .pix_b(req_chan.up_left_pixel), .threshold(thr_ff), .similar(flags.cul));
   upk_sim u_sim_cur (.clock(clock), .en(en), .pix_a(req_chan.center_pixel),
      .pix_b(req_chan.up_right_pixel), .threshold(thr_ff), .similar(flags.cur));
   upk_sim u_sim_cdl (.clock(clock), .en(en), .pix_a(req_chan.center_pixel),
      .pix_b(req_chan.down_left_pixel), .threshold(thr_ff), .similar(flags.cdl));
   upk_sim u_sim_cdr (.clock(clock), .en(en), .pix_a(req_chan.center_pixel),
      .pix_b(req_chan.down_right_pixel), .threshold(thr_ff), .similar(flags.cdr));

   // Block selection into the output register.
   upk_select u_select (
      .mode_3x (mode_ff),
      .flags   (flags),
      .c_pix   (carry_ff[DEPTH-1].c),
      .u_pix   (carry_ff[DEPTH-1].u),
      .d_pix   (carry_ff[DEPTH-1].d),
      .l_pix   (carry_ff[DEPTH-1].l),
      .r_pix   (carry_ff[DEPTH-1].r),
      .subs    (subs)
   );

   always_ff @(posedge clock) begin
      if (adv[DEPTH]) begin
         sub_ff <= subs;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.sub_0 = sub_ff[0];
   assign rsp_chan.sub_1 = sub_ff[1];
   assign rsp_chan.sub_2 = sub_ff[2];
   assign rsp_chan.sub_3 = sub_ff[3];
   assign rsp_chan.sub_4 = sub_ff[4];
   assign rsp_chan.sub_5 = sub_ff[5];
   assign rsp_chan.sub_6 = sub_ff[6];
   assign rsp_chan.sub_7 = sub_ff[7];
   assign rsp_chan.sub_8 = sub_ff[8];

endmodule

`default_nettype wire

// File: rtl/core/upk_checker.sv
// Port level checker for the upscale kernel, attached to the top level by bind.
// Depends on upk_pkg for widths and on the top level's channel ports.
`default_nettype none

module upk_checker (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_ready,
   input  wire                        rsp_valid,
   input  wire                        rsp_ready,
   input  wire [upk_pkg::PIXEL_W-1:0] rsp_sub_0,
   input  wire [upk_pkg::PIXEL_W-1:0] rsp_sub_8,
   input  wire                        csr_valid,
   input  wire                        csr_ready
);
   import upk_pkg::*;

   // A stalled result holds its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sub_0) && $stable(rsp_sub_8))
      else $error("stalled result changed");

   // Input stalls only while the output register holds an item.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with an empty output");

   // A draining output lets the whole pipeline advance.
   assert property (@(posedge clock) rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Register writes are never back-pressured.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind pixel_art_upscale_kernel_top upk_checker u_upk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_sub_0 (rsp_chan.sub_0),
   .rsp_sub_8 (rsp_chan.sub_8),
   .csr_valid (csr_chan.valid),
   .csr_ready (csr_chan.ready)
);

`default_nettype wire
